@@ hw/rtl/sat_pkg.sv @@
package sat_pkg;

  // Default geometry of the table memory.
  localparam int unsigned MAX_ROWS_DEF = 64;
  localparam int unsigned MAX_COLS_DEF = 64;

  // Fixed field widths of the stream items and the configuration channel.
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COORD_W = 6;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned DIM_W   = 7;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1
  } reg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_COORD = 2'd1,
    STATUS_NOT_READY = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_WR,
    ST_Q_R1,
    ST_Q_R2,
    ST_Q_R3,
    ST_Q_R4,
    ST_Q_OUT
  } state_e;

endpackage

@@ hw/rtl/summed_area_table_range_sum.sv @@
// Summed-area table with rectangle range sums.
// Input stream (s_axis_*): tuser carries the function bit. A load transaction
// streams the next matrix element in row-major order and produces no output;
// a query transaction names an inclusive rectangle and produces one output
// transaction with the wrapped 32-bit sum in tdata and a status code in tuser
// (ok, bad coordinates, or matrix not fully loaded; the sum is zero on error).
// The table lives in one synchronous single-read, single-write memory of
// MAX_ROWS x MAX_COLS words. A load does one memory read of the entry above,
// then the write-back. A query issues four reads one a cycle on the one read
// port, then passes the output stage (an error status goes straight to the
// output stage); the next item is taken once the output stage is done.
// One item is in work at a time.
// The configuration channel (cfg_*) writes rows_in_use (index 0) or
// cols_in_use (index 1); each write restarts loading. Writes to other indexes
// are ignored. Configuration is always accepted.
// Reset clears the load position and the table-ready flag and sets both
// dimensions to 64 (clamped to the memory size); the memory is not cleared.
// A finished result waits in the output register while m_axis_tready is low;
// new items are still accepted, and a later query holds before its output
// stage until the register is free.
module summed_area_table_range_sum #(
  parameter int unsigned MAX_ROWS = sat_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = sat_pkg::MAX_COLS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sat_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sat_pkg::DIM_W-1:0]       cfg_data_i,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: value[15:0], top_row[21:16], left_col[27:22], bottom_row[33:28],
  // right_col[39:34]
  input  logic [sat_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: func[0]
  input  logic                            s_axis_tuser,
  // Output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: sum[31:0]
  output logic [sat_pkg::SUM_W-1:0]       m_axis_tdata,
  // tuser: status[1:0]
  output logic [sat_pkg::STATUS_W-1:0]    m_axis_tuser
);
  import sat_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned mx);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > mx) begin
      res = DIM_W'(mx);
    end
    return res;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [31:0] row,
                                              input logic [31:0] col);
    logic [31:0] lin;
    lin = row * 32'(MAX_COLS) + col;
    return lin[AW-1:0];
  endfunction

  // Input fields.
  logic                   in_func;
  logic [VALUE_W-1:0]     in_value;
  logic [COORD_W-1:0]     in_top, in_left, in_bot, in_right;
  logic [SUM_W-1:0]       in_value_ext;

  assign in_func      = s_axis_tuser;
  assign in_value     = s_axis_tdata[15:0];
  assign in_top       = s_axis_tdata[21:16];
  assign in_left      = s_axis_tdata[27:22];
  assign in_bot       = s_axis_tdata[33:28];
  assign in_right     = s_axis_tdata[39:34];
  assign in_value_ext = {{(SUM_W-VALUE_W){in_value[VALUE_W-1]}}, in_value};

  // Control state.
  state_e                 state_q, state_d;
  logic [RW-1:0]          load_row_q, load_row_d;
  logic [CW-1:0]          load_col_q, load_col_d;
  logic [SUM_W-1:0]       run_sum_q, run_sum_d;
  logic                   ready_q, ready_d;
  logic [DIM_W-1:0]       rows_q, rows_d, cols_q, cols_d;
  logic                   out_valid_q, out_valid_d;

  // Payload registers.
  logic [SUM_W-1:0]       out_sum_q, out_sum_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;
  logic [SUM_W-1:0]       acc_q, acc_d;
  logic [COORD_W-1:0]     top_q, top_d, left_q, left_d, bot_q, bot_d, right_q, right_d;
  logic [STATUS_W-1:0]    status_q, status_d;
  logic                   above_ok_q, above_ok_d;
  logic [AW-1:0]          wr_addr_q, wr_addr_d;

  // Table memory.
  logic [SUM_W-1:0]       prefix_mem [DEPTH];
  logic [SUM_W-1:0]       rdata_q;
  logic [SUM_W-1:0]       wr_data;
  logic [AW-1:0]          rd_addr;
  logic                   mem_we;

  // Position of the next load; a finished matrix makes it start over.
  logic [RW-1:0]          row_eff;
  logic [CW-1:0]          col_eff;
  logic                   col_last, row_last, coord_bad;

  assign row_eff  = ready_q ? '0 : load_row_q;
  assign col_eff  = ready_q ? '0 : load_col_q;
  assign col_last = (32'(col_eff) + 32'd1) >= 32'(cols_q);
  assign row_last = (32'(row_eff) + 32'd1) >= 32'(rows_q);
  assign coord_bad = (in_top > in_bot) || (in_left > in_right) ||
                     (32'(in_bot) >= 32'(rows_q)) || (32'(in_right) >= 32'(cols_q));

  assign wr_data = run_sum_q + (above_ok_q ? rdata_q : '0);

  always_comb begin
    state_d      = state_q;
    load_row_d   = load_row_q;
    load_col_d   = load_col_q;
    run_sum_d    = run_sum_q;
    ready_d      = ready_q;
    rows_d       = rows_q;
    cols_d       = cols_q;
    out_valid_d  = out_valid_q;
    out_sum_d    = out_sum_q;
    out_status_d = out_status_q;
    acc_d        = acc_q;
    top_d        = top_q;
    left_d       = left_q;
    bot_d        = bot_q;
    right_d      = right_q;
    status_d     = status_q;
    above_ok_d   = above_ok_q;
    wr_addr_d    = wr_addr_q;
    rd_addr      = '0;
    mem_we       = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_func == FUNC_QUERY) begin
          rd_addr = cell_addr(32'(in_bot), 32'(in_right));
        end else begin
          rd_addr = cell_addr(32'(row_eff) - 32'd1, 32'(col_eff));
        end
        if (s_axis_tvalid) begin
          if (in_func == FUNC_LOAD) begin
            run_sum_d  = ((col_eff == '0) ? '0 : run_sum_q) + in_value_ext;
            above_ok_d = (row_eff != '0);
            wr_addr_d  = cell_addr(32'(row_eff), 32'(col_eff));
            ready_d    = col_last && row_last;
            if (col_last) begin
              load_col_d = '0;
              load_row_d = row_last ? '0 : row_eff + RW'(1);
            end else begin
              load_col_d = col_eff + CW'(1);
              load_row_d = row_eff;
            end
            state_d = ST_LD_WR;
          end else begin
            top_d   = in_top;
            left_d  = in_left;
            bot_d   = in_bot;
            right_d = in_right;
            acc_d   = '0;
            if (!ready_q) begin
              status_d = STATUS_NOT_READY;
              state_d  = ST_Q_OUT;
            end else if (coord_bad) begin
              status_d = STATUS_BAD_COORD;
              state_d  = ST_Q_OUT;
            end else begin
              status_d = STATUS_OK;
              state_d  = ST_Q_R1;
            end
          end
        end
      end
      ST_LD_WR: begin
        mem_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_Q_R1: begin
        acc_d   = rdata_q;
        rd_addr = cell_addr(32'(top_q) - 32'd1, 32'(right_q));
        state_d = ST_Q_R2;
      end
      ST_Q_R2: begin
        if (top_q != '0) begin
          acc_d = acc_q - rdata_q;
        end
        rd_addr = cell_addr(32'(bot_q), 32'(left_q) - 32'd1);
        state_d = ST_Q_R3;
      end
      ST_Q_R3: begin
        if (left_q != '0) begin
          acc_d = acc_q - rdata_q;
        end
        rd_addr = cell_addr(32'(top_q) - 32'd1, 32'(left_q) - 32'd1);
        state_d = ST_Q_R4;
      end
      ST_Q_R4: begin
        if ((top_q != '0) && (left_q != '0)) begin
          acc_d = acc_q + rdata_q;
        end
        state_d = ST_Q_OUT;
      end
      ST_Q_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_sum_d    = acc_q;
          out_status_d = status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A register write restarts loading of the matrix.
    if (cfg_valid_i) begin
      if (cfg_index_i == REG_ROWS || cfg_index_i == REG_COLS) begin
        if (cfg_index_i == REG_ROWS) begin
          rows_d = clamp_dim(cfg_data_i, MAX_ROWS);
        end else begin
          cols_d = clamp_dim(cfg_data_i, MAX_COLS);
        end
        load_row_d = '0;
        load_col_d = '0;
        run_sum_d  = '0;
        ready_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      load_row_q  <= '0;
      load_col_q  <= '0;
      run_sum_q   <= '0;
      ready_q     <= 1'b0;
      rows_q      <= clamp_dim(DIM_RESET, MAX_ROWS);
      cols_q      <= clamp_dim(DIM_RESET, MAX_COLS);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_row_q  <= load_row_d;
      load_col_q  <= load_col_d;
      run_sum_q   <= run_sum_d;
      ready_q     <= ready_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sum_q    <= out_sum_d;
    out_status_q <= out_status_d;
    acc_q        <= acc_d;
    top_q        <= top_d;
    left_q       <= left_d;
    bot_q        <= bot_d;
    right_q      <= right_d;
    status_q     <= status_d;
    above_ok_q   <= above_ok_d;
    wr_addr_q    <= wr_addr_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prefix_mem[wr_addr_q] <= wr_data;
    end
    rdata_q <= prefix_mem[rd_addr];
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sum_q;
  assign m_axis_tuser  = out_status_q;

endmodule

@@ tb/tb_summed_area_table_range_sum.sv @@
`timescale 1ns / 1ps

module tb_summed_area_table_range_sum;
  import sat_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1950;
  localparam int unsigned IDLE_PCT      = 31;
  localparam int unsigned CALM_FROM     = 700;
  localparam int unsigned CALM_TO       = 1000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned MEM_COLS      = MAX_COLS_DEF;
  localparam int unsigned MEM_DEPTH     = MAX_ROWS_DEF * MAX_COLS_DEF;

  // Indexes with no register behind them; writes to these must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [SUM_W-1:0] sum;
    status_e          status;
  } result_t;

  localparam result_t NO_RES        = '{32'h0, STATUS_OK};
  localparam result_t NOT_READY_RES = '{32'h0, STATUS_NOT_READY};
  localparam result_t BAD_RES       = '{32'h0, STATUS_BAD_COORD};

  typedef enum bit {
    ROW_CFG,
    ROW_ITEM
  } row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [DIM_W-1:0]     reg_data;
    func_e                func;
    logic [VALUE_W-1:0]   value;
    logic [COORD_W-1:0]   top_row;
    logic [COORD_W-1:0]   left_col;
    logic [COORD_W-1:0]   bottom_row;
    logic [COORD_W-1:0]   right_col;
    bit                   typed;
    result_t              want;
  } stim_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [DIM_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [SUM_W-1:0]     m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;

  // Mirror of the block: table contents, load position and dimensions.
  logic [SUM_W-1:0] sat_mem [MEM_DEPTH];
  int unsigned      fill_row;
  int unsigned      fill_col;
  logic [SUM_W-1:0] row_acc;
  bit               table_full;
  int unsigned      rows_eff;
  int unsigned      cols_eff;

  result_t     pending_sums [$];
  stim_row_t   directed_rows [33];
  int unsigned item_count;
  int unsigned fail_count;
  int unsigned stall_cycles;
  int unsigned hold_left;
  int unsigned phase;
  bit          calm;
  bit          hold_req;
  bit          held_off;

  summed_area_table_range_sum i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned fit_dim(input logic [DIM_W-1:0] raw,
                                          input int unsigned max_dim);
    if (raw == 0) return 1;
    if (raw > max_dim) return max_dim;
    return 32'(raw);
  endfunction

  function automatic void restart_fill();
    fill_row   = 0;
    fill_col   = 0;
    row_acc    = '0;
    table_full = 1'b0;
  endfunction

  function automatic void write_dim(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DIM_W-1:0] data);
    case (idx)
      REG_ROWS: begin
        rows_eff = fit_dim(data, MAX_ROWS_DEF);
        restart_fill();
      end
      REG_COLS: begin
        cols_eff = fit_dim(data, MAX_COLS_DEF);
        restart_fill();
      end
      default: ;
    endcase
  endfunction

  function automatic logic [SUM_W-1:0] sat_at(input int unsigned r, input int unsigned c);
    return sat_mem[r * MEM_COLS + c];
  endfunction

  // Advances the mirror by one input transaction; returns 1 when a result is due.
  function automatic bit sat_step(input func_e f, input logic [VALUE_W-1:0] v,
                                  input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] l,
                                  input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] r,
                                  output result_t res);
    logic [SUM_W-1:0] above;
    logic [SUM_W-1:0] acc;
    res = NO_RES;
    if (f == FUNC_LOAD) begin
      // A load after a complete matrix becomes element (0,0) of a new one.
      if (table_full) restart_fill();
      if (fill_col == 0) row_acc = '0;
      row_acc += {{(SUM_W - VALUE_W){v[VALUE_W-1]}}, v};
      above = (fill_row > 0) ? sat_at(fill_row - 1, fill_col) : '0;
      sat_mem[fill_row * MEM_COLS + fill_col] = row_acc + above;
      fill_col++;
      if (fill_col >= cols_eff) begin
        fill_col = 0;
        fill_row++;
        if (fill_row >= rows_eff) begin
          fill_row   = 0;
          table_full = 1'b1;
        end
      end
      return 1'b0;
    end
    if (!table_full) begin
      res.status = STATUS_NOT_READY;
    end else if (t > b || l > r || b >= rows_eff || r >= cols_eff) begin
      res.status = STATUS_BAD_COORD;
    end else begin
      acc = sat_at(b, r);
      if (t > 0) acc -= sat_at(t - 1, r);
      if (l > 0) acc -= sat_at(b, l - 1);
      if (t > 0 && l > 0) acc += sat_at(t - 1, l - 1);
      res.sum = acc;
    end
    return 1'b1;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Lowers both request lines, waits for every pending result and lets a
  // trailing load finish before the caller touches the registers.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high so that back-to-back writes need no gap.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    write_dim(idx, data);
  endtask

  task automatic offer_item(input func_e f, input logic [VALUE_W-1:0] v,
                            input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] l,
                            input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] r,
                            input bit typed, input result_t want);
    result_t res;
    calm = item_count >= CALM_FROM && item_count < CALM_TO;
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, b, l, t, v};
    s_axis_tuser  <= f;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    if (sat_step(f, v, t, l, b, r, res)) pending_sums.push_back(typed ? want : res);
    item_count++;
  endtask

  task automatic offer_query(input bit in_range);
    logic [COORD_W-1:0] t, l, b, r;
    if (in_range) begin
      t = COORD_W'($urandom_range(0, rows_eff - 1));
      b = COORD_W'($urandom_range(t, rows_eff - 1));
      l = COORD_W'($urandom_range(0, cols_eff - 1));
      r = COORD_W'($urandom_range(l, cols_eff - 1));
    end else begin
      t = COORD_W'($urandom);
      l = COORD_W'($urandom);
      b = COORD_W'($urandom);
      r = COORD_W'($urandom);
    end
    offer_item(FUNC_QUERY, VALUE_W'($urandom), t, l, b, r, 1'b0, NO_RES);
  endtask

  task automatic offer_load();
    offer_item(FUNC_LOAD, pick_value(), COORD_W'($urandom), COORD_W'($urandom),
               COORD_W'($urandom), COORD_W'($urandom), 1'b0, NO_RES);
  endtask

  task automatic load_and_query();
    int unsigned total;
    int unsigned stop_at;
    total   = rows_eff * cols_eff;
    stop_at = total;
    // Some matrices are abandoned partway so the next register write lands mid-load.
    if (total > 1 && $urandom_range(0, 4) == 0) stop_at = $urandom_range(1, total - 1);
    for (int unsigned i = 0; i < stop_at; i++) begin
      offer_load();
      if ($urandom_range(0, 9) == 0) offer_query(1'b1);
    end
    if (stop_at < total) return;
    if (!held_off && phase >= 4) begin
      hold_req = 1'b1;
      held_off = 1'b1;
    end
    repeat ($urandom_range(8, 30)) offer_query($urandom_range(0, 99) < 85);
    if ($urandom_range(0, 3) == 0) begin
      offer_load();
      offer_query(1'b1);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Handshakes are sampled mid-cycle, where inputs and outputs are stable.
  always @(negedge clk_i) begin : check_output
    result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result transaction: sum %0d status %0d",
               $signed(m_axis_tdata), m_axis_tuser);
        fail_count++;
      end else begin
        exp_r = pending_sums.pop_front();
        if (m_axis_tdata !== exp_r.sum) begin
          $error("sum mismatch: expected %0d, actual %0d",
                 $signed(exp_r.sum), $signed(m_axis_tdata));
          fail_count++;
        end
        if (m_axis_tuser !== exp_r.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_r.status, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [DIM_W-1:0] raw_rows;
    logic [DIM_W-1:0] raw_cols;

    for (int i = 0; i < MEM_DEPTH; i++) sat_mem[i] = '0;
    rows_eff = fit_dim(DIM_RESET, MAX_ROWS_DEF);
    cols_eff = fit_dim(DIM_RESET, MAX_COLS_DEF);
    restart_fill();

    directed_rows = '{
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 0,  0,  0,  0,  1, NOT_READY_RES},
      '{ROW_CFG,  REG_ROWS,    7'd0,   FUNC_LOAD,  16'h0000, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_CFG,  REG_COLS,    7'd2,   FUNC_LOAD,  16'h0000, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_CFG,  REG_SPARE_A, 7'd5,   FUNC_LOAD,  16'h0000, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_CFG,  REG_SPARE_B, 7'd127, FUNC_LOAD,  16'h0000, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_LOAD,  16'h7FFF, 63, 63, 63, 63, 0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'hFFFF, 0,  0,  0,  1,  1, NOT_READY_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_LOAD,  16'h8000, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 0,  0,  0,  1,  1,
        '{32'hFFFF_FFFF, STATUS_OK}},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 0,  1,  0,  1,  0, NO_RES},
      '{ROW_CFG,  REG_ROWS,    7'd2,   FUNC_LOAD,  16'h0000, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 0,  0,  1,  1,  1, NOT_READY_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_LOAD,  16'h0001, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_LOAD,  16'hFFFE, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_LOAD,  16'h0003, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_LOAD,  16'h7FFF, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 0,  0,  1,  1,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 1,  1,  1,  1,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 1,  0,  1,  1,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 0,  1,  1,  1,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 1,  0,  0,  0,  1, BAD_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 0,  1,  0,  0,  1, BAD_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 0,  0,  2,  0,  1, BAD_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 0,  0,  0,  2,  1, BAD_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 63, 63, 63, 63, 1, BAD_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_LOAD,  16'h0005, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 0,  0,  0,  0,  1, NOT_READY_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_LOAD,  16'h0006, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_LOAD,  16'h0007, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_LOAD,  16'h0008, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_ITEM, REG_ROWS,    7'd0,   FUNC_QUERY, 16'h0000, 0,  0,  1,  1,  0, NO_RES},
      '{ROW_CFG,  REG_ROWS,    7'd127, FUNC_LOAD,  16'h0000, 0,  0,  0,  0,  0, NO_RES},
      '{ROW_CFG,  REG_COLS,    7'd1,   FUNC_LOAD,  16'h0000, 0,  0,  0,  0,  0, NO_RES}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (!cfg_valid_i) drain_results();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        if (cfg_valid_i) cfg_valid_i <= 1'b0;
        offer_item(directed_rows[i].func, directed_rows[i].value, directed_rows[i].top_row,
                   directed_rows[i].left_col, directed_rows[i].bottom_row,
                   directed_rows[i].right_col, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Each phase picks new dimensions; one side is kept small so a matrix stays short.
    while (item_count < ITEM_TARGET) begin
      drain_results();
      case ($urandom_range(0, 9))
        0: begin
          raw_rows = DIM_W'($urandom_range(64, 127));
          raw_cols = DIM_W'($urandom_range(0, 2));
        end
        1: begin
          raw_rows = DIM_W'($urandom_range(0, 2));
          raw_cols = DIM_W'($urandom_range(64, 127));
        end
        default: begin
          raw_rows = DIM_W'($urandom_range(0, 6));
          raw_cols = DIM_W'($urandom_range(0, 6));
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_ROWS, raw_rows);
        write_reg(REG_COLS, raw_cols);
      end else begin
        write_reg(REG_COLS, raw_cols);
        write_reg(REG_ROWS, raw_rows);
      end
      if ($urandom_range(0, 5) == 0) begin
        write_reg(CFG_IDX_W'(REG_SPARE_A + $urandom_range(0, 1)), DIM_W'($urandom));
      end
      cfg_valid_i <= 1'b0;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(10, 25)) begin
          if ($urandom_range(0, 1) == 0) offer_load();
          else offer_query($urandom_range(0, 1) == 0);
        end
      end else begin
        load_and_query();
      end
      phase++;
    end

    drain_results();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/sat_pkg.sv
hw/rtl/summed_area_table_range_sum.sv
tb/tb_summed_area_table_range_sum.sv
